[rtl/core/prg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prg_pkg
// Shared types and constants of the pinhole ray generator pipeline.
// ----------------------------------------------------------------------------
package prg_pkg;

	localparam int CFG_W   = 48;
	localparam int IDX_W   = 3;
	localparam int PIX_W   = 12;
	localparam int ENT_W   = 16;
	localparam int C_W     = 18;
	localparam int PROD_W  = 34;
	localparam int R_W     = 36;
	localparam int MAG_W   = 36;
	localparam int LEAD_W  = 6;
	localparam int NORM_W  = 30;
	localparam int SQ_W    = 60;
	localparam int SUM_W   = 62;
	localparam int ROOT_W  = 31;
	localparam int FRAC_W  = 14;
	localparam int NUM_W   = 46;
	localparam int QUO_W   = 15;
	localparam int DIR_W   = 16;

	localparam logic [QUO_W-1:0] ONE_Q14 = 15'd16384;

	localparam logic [IDX_W-1:0] REG_ROT0  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROT1  = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROT2  = 3'd2;
	localparam logic [IDX_W-1:0] REG_TRANS = 3'd3;
	localparam logic [IDX_W-1:0] REG_PX    = 3'd4;
	localparam logic [IDX_W-1:0] REG_PY    = 3'd5;
	localparam logic [IDX_W-1:0] REG_FOCAL = 3'd6;

	localparam logic [CFG_W-1:0] ROT0_RST  = 48'h4000_0000_0000;
	localparam logic [CFG_W-1:0] ROT1_RST  = 48'h0000_4000_0000;
	localparam logic [CFG_W-1:0] ROT2_RST  = 48'h0000_0000_4000;
	localparam logic [ENT_W-1:0] FOCAL_RST = 16'd16;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_col;
		logic [PIX_W-1:0] pixel_row;
	} ray_in_t;

	typedef struct packed {
		logic signed [ENT_W-1:0] origin_x;
		logic signed [ENT_W-1:0] origin_y;
		logic signed [ENT_W-1:0] origin_z;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
	} ray_out_t;

	typedef struct packed {
		logic [2:0][NORM_W-1:0] mag;
		logic [2:0]             neg;
		logic                   zero;
	} vec_t;

endpackage

[rtl/core/prg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prg_front
// Pixel to camera vector, rotation, block normalization and sum of squares.
// ----------------------------------------------------------------------------
module prg_front import prg_pkg::*; #(
	parameter int IMAGE_DIM_MAX = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  vld,
	input  ray_in_t               pix,
	input  logic [2:0][CFG_W-1:0] rot,
	input  logic [ENT_W-1:0]      px,
	input  logic [ENT_W-1:0]      py,
	input  logic [ENT_W-1:0]      focal,
	output logic                  vld_o,
	output logic [SUM_W-1:0]      sum_o,
	output vec_t                  vec_o
);

	localparam logic [14:0] LIM = 15'(IMAGE_DIM_MAX - 1);

	logic [7:0] vld_q;

	logic signed [C_W-1:0]    c_s1 [3];
	logic signed [PROD_W-1:0] p_s2 [3][3];
	logic signed [R_W-1:0]    r_s3 [3];
	logic [MAG_W-1:0]         mag_s4 [3];
	logic [2:0]               neg_s4;
	logic [MAG_W-1:0]         or_s4;
	logic [MAG_W-1:0]         mag_s5 [3];
	logic [2:0]               neg_s5;
	logic [LEAD_W-1:0]        lead_s5;
	logic                     zero_s5;
	vec_t                     vec_s6;
	vec_t                     vec_s7;
	logic [SQ_W-1:0]          sq_s7 [3];
	vec_t                     vec_s8;
	logic [SUM_W-1:0]         sum_s8;

	logic [PIX_W-1:0]  u, v;
	logic [MAG_W-1:0]  abs_c [3];
	logic [LEAD_W-1:0] lead_c;
	vec_t              norm_c;

	always_comb begin
		u = ({3'b000, pix.pixel_col} > LIM) ? LIM[PIX_W-1:0] : pix.pixel_col;
		v = ({3'b000, pix.pixel_row} > LIM) ? LIM[PIX_W-1:0] : pix.pixel_row;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_c[i] = r_s3[i][R_W-1] ? MAG_W'(unsigned'(-r_s3[i])) : MAG_W'(unsigned'(r_s3[i]));
		end
	end

	always_comb begin
		lead_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (or_s4[i]) begin
				lead_c = LEAD_W'(i);
			end
		end
	end

	always_comb begin
		norm_c.neg  = neg_s5;
		norm_c.zero = zero_s5;
		for (int i = 0; i < 3; i++) begin
			if (lead_s5 >= LEAD_W'(NORM_W - 1)) begin
				norm_c.mag[i] = NORM_W'(mag_s5[i] >> (lead_s5 - LEAD_W'(NORM_W - 1)));
			end else begin
				norm_c.mag[i] = NORM_W'(mag_s5[i] << (LEAD_W'(NORM_W - 1) - lead_s5));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[6:0], vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1[0] <= signed'({2'b00, u, 4'b0000}) - signed'({2'b00, px});
			c_s1[1] <= signed'({2'b00, v, 4'b0000}) - signed'({2'b00, py});
			c_s1[2] <= signed'({2'b00, focal});
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s2[i][j] <= signed'(rot[i][ENT_W*j +: ENT_W]) * c_s1[j];
				end
				r_s3[i] <= R_W'(p_s2[i][0]) + R_W'(p_s2[i][1]) + R_W'(p_s2[i][2]);
				mag_s4[i] <= abs_c[i];
				neg_s4[i] <= r_s3[i][R_W-1];
				mag_s5[i] <= mag_s4[i];
				sq_s7[i]  <= SQ_W'(vec_s6.mag[i] * vec_s6.mag[i]);
			end
			or_s4   <= abs_c[0] | abs_c[1] | abs_c[2];
			neg_s5  <= neg_s4;
			lead_s5 <= lead_c;
			zero_s5 <= (or_s4 == '0);
			vec_s6  <= norm_c;
			vec_s7  <= vec_s6;
			vec_s8  <= vec_s7;
			sum_s8  <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
		end
	end

	assign vld_o = vld_q[7];
	assign sum_o = sum_s8;
	assign vec_o = vec_s8;

endmodule

[rtl/core/prg_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prg_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module prg_sqrt import prg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              vld,
	input  logic [SUM_W-1:0]  sum,
	input  vec_t              vec,
	output logic              vld_o,
	output logic [ROOT_W-1:0] root_o,
	output vec_t              vec_o
);

	logic              vld_s  [ROOT_W+1];
	logic [SUM_W-1:0]  rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	vec_t              vec_s  [ROOT_W+1];

	assign vld_s[0]  = vld;
	assign rem_s[0]  = sum;
	assign root_s[0] = '0;
	assign vec_s[0]  = vec;

	for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
		localparam int B = ROOT_W - 1 - g;
		logic [SUM_W-1:0] trial;

		assign trial = (SUM_W'(root_s[g]) << (B + 1)) | (SUM_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				vec_s[g+1] <= vec_s[g];
				if (rem_s[g] >= trial) begin
					rem_s[g+1]  <= rem_s[g] - trial;
					root_s[g+1] <= root_s[g] | (ROOT_W'(1) << B);
				end else begin
					rem_s[g+1]  <= rem_s[g];
					root_s[g+1] <= root_s[g];
				end
			end
		end
	end

	assign vld_o  = vld_s[ROOT_W];
	assign root_o = root_s[ROOT_W];
	assign vec_o  = vec_s[ROOT_W];

endmodule

[rtl/core/prg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prg_div
// Three-lane pipelined rounding divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module prg_div import prg_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         vld,
	input  logic [ROOT_W-1:0]            root,
	input  vec_t                         vec,
	output logic                         vld_o,
	output logic signed [2:0][DIR_W-1:0] dir_o
);

	logic                   vld_s  [QUO_W+2];
	logic [2:0][NUM_W-1:0]  rem_s  [QUO_W+1];
	logic [2:0][QUO_W-1:0]  quo_s  [QUO_W+1];
	logic [ROOT_W-1:0]      den_s  [QUO_W+1];
	logic [2:0]             neg_s  [QUO_W+1];
	logic                   zero_s [QUO_W+1];
	logic [2:0][DIR_W-1:0]  dir_s;

	assign vld_s[0] = vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= vld_s[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= (NUM_W'(vec.mag[l]) << FRAC_W) + NUM_W'(root >> 1);
			end
			quo_s[0]  <= '0;
			den_s[0]  <= root;
			neg_s[0]  <= vec.neg;
			zero_s[0] <= vec.zero;
		end
	end

	for (genvar g = 0; g < QUO_W; g++) begin : g_stage
		localparam int B = QUO_W - 1 - g;
		logic [NUM_W-1:0] dv;

		assign dv = NUM_W'(den_s[g]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+2] <= 1'b0;
			end else if (adv) begin
				vld_s[g+2] <= vld_s[g+1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				den_s[g+1]  <= den_s[g];
				neg_s[g+1]  <= neg_s[g];
				zero_s[g+1] <= zero_s[g];
				for (int l = 0; l < 3; l++) begin
					if (rem_s[g][l] >= dv) begin
						rem_s[g+1][l] <= rem_s[g][l] - dv;
						quo_s[g+1][l] <= quo_s[g][l] | (QUO_W'(1) << B);
					end else begin
						rem_s[g+1][l] <= rem_s[g][l];
						quo_s[g+1][l] <= quo_s[g][l];
					end
				end
			end
		end
	end

	logic vld_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (adv) begin
			vld_out_q <= vld_s[QUO_W+1];
		end
	end

	always_ff @(posedge clk) begin
		logic [QUO_W-1:0] q;
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				q = (quo_s[QUO_W][l] > ONE_Q14) ? ONE_Q14 : quo_s[QUO_W][l];
				if (zero_s[QUO_W]) begin
					dir_s[l] <= '0;
				end else if (neg_s[QUO_W][l]) begin
					dir_s[l] <= DIR_W'(0) - DIR_W'(q);
				end else begin
					dir_s[l] <= DIR_W'(q);
				end
			end
		end
	end

	assign vld_o = vld_out_q;
	assign dir_o = dir_s;

endmodule

[rtl/core/prg_obuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prg_obuf
// Two-entry output buffer; pipeline advance comes from its registered fill.
// ----------------------------------------------------------------------------
module prg_obuf import prg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_vld,
	input  logic [2:0][DIR_W-1:0] push_dir,
	input  logic                  stall,
	output logic                  adv,
	output logic                  valid,
	output logic [2:0][DIR_W-1:0] dir
);

	logic [1:0]            cnt_q;
	logic                  wr_q, rd_q;
	logic [2:0][DIR_W-1:0] ent_q [2];
	logic                  push, pop;

	assign adv   = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign push  = adv & push_vld;
	assign pop   = valid & ~stall;
	assign dir   = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_dir;
		end
	end

endmodule

[rtl/core/pinhole_ray_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_ray_generator
// Pixel coordinate in, pinhole camera ray (origin and unit direction) out.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------
//   input    | in_valid/in_stall  | in_data  : ray_in_t  (pixel_col, row)
//   output   | out_valid/out_stall| out_data : ray_out_t (origin, dir)
//   config   | cfg_wr_en          | cfg_index, cfg_data (48 bits)
//
// One ray per cycle while the output buffer has room; output valid follows
// the input beat via 8 front stages, the 31-stage square root, the divider
// (15 quotient stages plus entry and output registers), then the buffer.
// Reset clears valid bits and loads the register defaults.
// A two-entry output buffer parts the sides: input stalls only when both
// entries hold results, then the whole pipeline holds.
// ----------------------------------------------------------------------------
module pinhole_ray_generator import prg_pkg::*; #(
	parameter int IMAGE_DIM_MAX = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ray_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ray_out_t         out_data,
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [2:0][CFG_W-1:0] rot_q;
	logic [CFG_W-1:0]      trans_q;
	logic [ENT_W-1:0]      px_q, py_q, focal_q;

	logic                  adv;
	logic                  f_vld, s_vld, d_vld;
	logic [SUM_W-1:0]      f_sum;
	vec_t                  f_vec, s_vec;
	logic [ROOT_W-1:0]     s_root;
	logic [2:0][DIR_W-1:0] d_dir, o_dir;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= ROT0_RST;
			rot_q[1] <= ROT1_RST;
			rot_q[2] <= ROT2_RST;
			trans_q  <= '0;
			px_q     <= '0;
			py_q     <= '0;
			focal_q  <= FOCAL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROT0:  rot_q[0] <= cfg_data;
				REG_ROT1:  rot_q[1] <= cfg_data;
				REG_ROT2:  rot_q[2] <= cfg_data;
				REG_TRANS: trans_q  <= cfg_data;
				REG_PX:    px_q     <= cfg_data[ENT_W-1:0];
				REG_PY:    py_q     <= cfg_data[ENT_W-1:0];
				REG_FOCAL: focal_q  <= cfg_data[ENT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = ~adv;

	prg_front #(
		.IMAGE_DIM_MAX(IMAGE_DIM_MAX)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.vld   (in_valid),
		.pix   (in_data),
		.rot   (rot_q),
		.px    (px_q),
		.py    (py_q),
		.focal (focal_q),
		.vld_o (f_vld),
		.sum_o (f_sum),
		.vec_o (f_vec)
	);

	prg_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.vld   (f_vld),
		.sum   (f_sum),
		.vec   (f_vec),
		.vld_o (s_vld),
		.root_o(s_root),
		.vec_o (s_vec)
	);

	prg_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.vld   (s_vld),
		.root  (s_root),
		.vec   (s_vec),
		.vld_o (d_vld),
		.dir_o (d_dir)
	);

	prg_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_vld(d_vld),
		.push_dir(d_dir),
		.stall   (out_stall),
		.adv     (adv),
		.valid   (out_valid),
		.dir     (o_dir)
	);

	// origin follows the translation register; the user must change it only when idle, the block does not enforce this
	always_comb begin
		out_data.origin_x = signed'(trans_q[15:0]);
		out_data.origin_y = signed'(trans_q[31:16]);
		out_data.origin_z = signed'(trans_q[47:32]);
		out_data.dir_x    = signed'(o_dir[0]);
		out_data.dir_y    = signed'(o_dir[1]);
		out_data.dir_z    = signed'(o_dir[2]);
	end

endmodule

[tb/sv/pinhole_ray_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_ray_generator_tb
// Drives pixel beats through the ray generator under random idling and
// stalls and compares each ray with a predicted ray, field by field.
// The prediction is computed in the testbench. The camera pose and the
// intrinsics are reprogrammed between phases, the extremes among them.
// ----------------------------------------------------------------------------
module pinhole_ray_generator_tb;
	import prg_pkg::*;

	localparam int DIM_MAX = 4096;
	localparam int LATENCY = 58;
	localparam longint CYCLE_LIMIT = 400000;

	class ray_scoreboard;
		logic [CFG_W-1:0] pose [7];
		ray_out_t         pending [$];
		int               errors;

		function void load_defaults();
			pose[REG_ROT0]  = ROT0_RST;
			pose[REG_ROT1]  = ROT1_RST;
			pose[REG_ROT2]  = ROT2_RST;
			pose[REG_TRANS] = '0;
			pose[REG_PX]    = '0;
			pose[REG_PY]    = '0;
			pose[REG_FOCAL] = FOCAL_RST;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx > REG_FOCAL)
				return;
			pose[idx] = (idx >= REG_PX) ? {32'd0, val[15:0]} : val;
		endfunction

		function longint unsigned root64(longint unsigned s);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > s)
				bitv >>= 2;
			while (bitv != 0) begin
				if (s >= res + bitv) begin
					s -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function ray_out_t trace(ray_in_t px);
			ray_out_t        ray;
			longint          cam [3];
			longint          rot [3];
			longint unsigned mag [3];
			longint unsigned peak, sum, root, q;
			logic [11:0]     u, v;
			logic [15:0]     ent;
			u = px.pixel_col > DIM_MAX - 1 ? 12'(DIM_MAX - 1) : px.pixel_col;
			v = px.pixel_row > DIM_MAX - 1 ? 12'(DIM_MAX - 1) : px.pixel_row;
			cam[0] = longint'(u) * 16 - longint'(pose[REG_PX]);
			cam[1] = longint'(v) * 16 - longint'(pose[REG_PY]);
			cam[2] = longint'(pose[REG_FOCAL]);
			for (int i = 0; i < 3; i++) begin
				rot[i] = 0;
				for (int j = 0; j < 3; j++) begin
					ent = pose[i][16*j +: 16];
					rot[i] += longint'($signed(ent)) * cam[j];
				end
				mag[i] = rot[i] < 0 ? -rot[i] : rot[i];
			end
			ray.origin_x = pose[REG_TRANS][15:0];
			ray.origin_y = pose[REG_TRANS][31:16];
			ray.origin_z = pose[REG_TRANS][47:32];
			peak = mag[0];
			if (mag[1] > peak) peak = mag[1];
			if (mag[2] > peak) peak = mag[2];
			if (peak == 0) begin
				ray.dir_x = '0;
				ray.dir_y = '0;
				ray.dir_z = '0;
				return ray;
			end
			while (peak >= (64'd1 << 30)) begin
				for (int i = 0; i < 3; i++) mag[i] >>= 1;
				peak >>= 1;
			end
			while (peak < (64'd1 << 29)) begin
				for (int i = 0; i < 3; i++) mag[i] <<= 1;
				peak <<= 1;
			end
			sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
			root = root64(sum);
			if (root == 0) root = 1;
			for (int i = 0; i < 3; i++) begin
				q = (mag[i] * 16384 + (root >> 1)) / root;
				if (q > 16384) q = 16384;
				if (rot[i] < 0) q = -q;
				case (i)
					0: ray.dir_x = q[15:0];
					1: ray.dir_y = q[15:0];
					default: ray.dir_z = q[15:0];
				endcase
			end
			return ray;
		endfunction

		function void note_pixel(ray_in_t px);
			pending.push_back(trace(px));
		endfunction

		function void report(string what, longint got, longint want);
			$display("ray %s: got %0d, want %0d", what, got, want);
			errors++;
		endfunction

		function void check_ray(ray_out_t got);
			ray_out_t want;
			if (pending.size() == 0) begin
				report("without pending pixel", 0, 0);
				return;
			end
			want = pending.pop_front();
			if (got.origin_x !== want.origin_x) report("origin_x", got.origin_x, want.origin_x);
			if (got.origin_y !== want.origin_y) report("origin_y", got.origin_y, want.origin_y);
			if (got.origin_z !== want.origin_z) report("origin_z", got.origin_z, want.origin_z);
			if (got.dir_x !== want.dir_x) report("dir_x", got.dir_x, want.dir_x);
			if (got.dir_y !== want.dir_y) report("dir_y", got.dir_y, want.dir_y);
			if (got.dir_z !== want.dir_z) report("dir_z", got.dir_z, want.dir_z);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	ray_in_t          in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	ray_out_t         out_data;
	logic             cfg_wr_en = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	ray_scoreboard rays = new();
	bit            idle_enable = 1'b1;
	bit            hold_output = 1'b0;
	longint        cycles = 0;

	pinhole_ray_generator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pinhole_ray_generator: mismatch");
			$finish;
		end
	end

	// output side: check on accepted beats, then choose next stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				rays.check_ray(out_data);
			out_stall <= hold_output || (idle_enable && $urandom_range(99) < 24);
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		rays.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic drain();
		while (rays.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// sends one beat; valid stays high across back-to-back beats
	task automatic send_pixel(logic [11:0] col, logic [11:0] row);
		ray_in_t px;
		px.pixel_col = col;
		px.pixel_row = row;
		while (idle_enable && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		rays.note_pixel(px);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_entry();
		case ($urandom_range(3))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_pose();
		write_reg(REG_ROT0, {rand_entry(), rand_entry(), rand_entry()});
		write_reg(REG_ROT1, {rand_entry(), rand_entry(), rand_entry()});
		write_reg(REG_ROT2, {rand_entry(), rand_entry(), rand_entry()});
		write_reg(REG_TRANS, {16'($urandom), 16'($urandom), 16'($urandom)});
		write_reg(REG_PX, $urandom_range(1) ? 16'($urandom) : 16'($urandom & 32'h7FFF));
		write_reg(REG_PY, 16'($urandom));
		write_reg(REG_FOCAL, $urandom_range(3) == 0 ? 16'd0 : 16'($urandom));
	endtask

	initial begin
		rays.load_defaults();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default pose, pixel extremes
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'hFFF, 12'd0);
		send_pixel(12'd0, 12'hFFF);
		send_pixel(12'h555, 12'hAAA);
		end_burst();
		drain();

		// zero rotation gives zero direction; out-of-range index ignored
		write_reg(REG_ROT0, '0);
		write_reg(REG_ROT1, '0);
		write_reg(REG_ROT2, '0);
		write_reg(3'd7, '1);
		send_pixel(12'd17, 12'd99);
		end_burst();
		drain();

		// extreme pose, zero focal length, principal at top of range
		write_reg(REG_ROT0, '1);
		write_reg(REG_ROT1, {3{16'h8000}});
		write_reg(REG_ROT2, {3{16'h7FFF}});
		write_reg(REG_TRANS, {16'h8000, 16'h7FFF, 16'hFFFF});
		write_reg(REG_PX, 16'hFFFF);
		write_reg(REG_PY, 16'hFFFF);
		write_reg(REG_FOCAL, 16'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'd100, 12'd3000);
		end_burst();
		drain();
		write_reg(REG_FOCAL, 16'hFFFF);
		send_pixel(12'd0, 12'hFFF);
		send_pixel(12'hFFF, 12'd0);
		end_burst();
		drain();
		write_reg(REG_PX, 16'd0);
		write_reg(REG_PY, 16'd0);
		write_reg(REG_FOCAL, 16'd1);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);
		end_burst();
		drain();

		// back-pressure: receiver holds while sender keeps offering
		fork
			begin
				hold_output = 1'b1;
				repeat (200) @(posedge clk);
				hold_output = 1'b0;
			end
			for (int i = 0; i < 100; i++)
				send_pixel(12'($urandom), 12'($urandom));
		join
		end_burst();
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			random_pose();
			idle_enable = (ph != 5);
			for (int i = 0; i < 150; i++)
				send_pixel(12'($urandom), 12'($urandom));
			end_burst();
			drain();
		end
		idle_enable = 1'b1;

		repeat (LATENCY + 8) @(posedge clk);
		if (rays.errors == 0 && rays.pending.size() == 0)
			$display("pinhole_ray_generator: match");
		else
			$display("pinhole_ray_generator: mismatch");
		$finish;
	end

endmodule

[files.f]
rtl/core/prg_pkg.sv
rtl/core/prg_front.sv
rtl/core/prg_sqrt.sv
rtl/core/prg_div.sv
rtl/core/prg_obuf.sv
rtl/core/pinhole_ray_generator.sv
tb/sv/pinhole_ray_generator_tb.sv
